// ===== hw/rtl/run_region_moments_unit_macros.svh =====
// Assertion macros shared by the checker of the run region moments unit.
`ifndef RUN_REGION_MOMENTS_UNIT_MACROS_SVH
`define RUN_REGION_MOMENTS_UNIT_MACROS_SVH

// Checks a property while reset is low.
`define RRM_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property at every clock edge, reset included.
`define RRM_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/rrm_pkg.sv =====
// Types and constants of the run region moments unit.
package rrm_pkg;

   localparam int AREA_OUT_W  = 25;
   localparam int CENT_W      = 20;
   localparam int MOM_W       = 56;
   localparam int RSP_DW      = 240;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic ok;
      logic last;
   } rrm_ctl_type;

   typedef enum logic [2:0] {
      FIN_IDLE,
      FIN_MSET,
      FIN_MUL,
      FIN_PREP,
      FIN_LOAD,
      FIN_DIV,
      FIN_SAVE,
      FIN_OUT
   } fin_state_type;

   localparam logic [2:0] MJ_RCA = 3'd0;
   localparam logic [2:0] MJ_RC  = 3'd1;
   localparam logic [2:0] MJ_CSA = 3'd2;
   localparam logic [2:0] MJ_CC  = 3'd3;
   localparam logic [2:0] MJ_RSA = 3'd4;
   localparam logic [2:0] MJ_RR  = 3'd5;

   localparam logic [2:0] DJ_CROW = 3'd0;
   localparam logic [2:0] DJ_CCOL = 3'd1;
   localparam logic [2:0] DJ_MIX  = 3'd2;
   localparam logic [2:0] DJ_CMOM = 3'd3;
   localparam logic [2:0] DJ_RMOM = 3'd4;

endpackage

// ===== hw/rtl/run_region_moments_unit.sv =====
// Run region moments unit: runs in (one per cycle unless stalled), area, centroid and central moments out.
// Runs flow at one transaction per cycle, unless held, through a 4-entry queue and a run pipeline.
// After the last run of a region, a bit-serial multiplier and divider compute its result.
// Runs of the next region queue up meanwhile; the pipeline holds only at the next region end.
// A synchronous reset empties the queue and the pipeline and clears all region sums.
module run_region_moments_unit
   import rrm_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 8,
   localparam int REQ_DW = ((3*COORD_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,  // run_row, first_col, final_col, zero fill
   input  logic              req_tuser,  // has_run
   input  logic              req_tlast,  // region_end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,  // region_area, centroid_row, centroid_col,
                                         // mixed_moment, col_moment, row_moment, zero fill
   output logic              rsp_tuser   // status
);

   localparam int C = COORD_BITS;

   logic           pop, head_valid, fin_busy, fin_start;
   logic [C-1:0]   head_row, head_first, head_final;
   rrm_ctl_type    head_ctl;
   logic [2*C:0]   area_nx;
   logic [3*C:0]   rsum_nx, csum_nx;
   logic [4*C:0]   rsq_nx, rcs_nx, csq_nx;

   logic [AREA_OUT_W-1:0] region_area;
   logic [CENT_W-1:0]     centroid_row, centroid_col;
   logic [MOM_W-1:0]      mixed_moment, col_moment, row_moment;

   rrm_front #(.C(C), .DW(REQ_DW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .head_valid (head_valid),
      .head_row   (head_row),
      .head_first (head_first),
      .head_final (head_final),
      .head_ctl   (head_ctl)
   );

   rrm_accum #(.C(C)) u_accum (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_row   (head_row),
      .head_first (head_first),
      .head_final (head_final),
      .head_ctl   (head_ctl),
      .pop        (pop),
      .fin_busy   (fin_busy),
      .fin_start  (fin_start),
      .area_nx    (area_nx),
      .rsum_nx    (rsum_nx),
      .csum_nx    (csum_nx),
      .rsq_nx     (rsq_nx),
      .rcs_nx     (rcs_nx),
      .csq_nx     (csq_nx)
   );

   rrm_finish #(.C(C), .F(FRAC_BITS)) u_finish (
      .clock        (clock),
      .reset        (reset),
      .start        (fin_start),
      .area         (area_nx),
      .rsum         (rsum_nx),
      .csum         (csum_nx),
      .rsq          (rsq_nx),
      .rcs          (rcs_nx),
      .csq          (csq_nx),
      .busy         (fin_busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .status       (rsp_tuser),
      .region_area  (region_area),
      .centroid_row (centroid_row),
      .centroid_col (centroid_col),
      .mixed_moment (mixed_moment),
      .col_moment   (col_moment),
      .row_moment   (row_moment)
   );

   assign rsp_tdata = {7'd0, row_moment, col_moment, mixed_moment,
                       centroid_col, centroid_row, region_area};

endmodule

// ===== hw/rtl/rrm_front.sv =====
// Input side: accepts run transactions, classifies them and queues them.
module rrm_front
   import rrm_pkg::*;
#(
   parameter int C = 12,
   parameter int DW = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [DW-1:0] req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   input  logic         pop,
   output logic         head_valid,
   output logic [C-1:0] head_row,
   output logic [C-1:0] head_first,
   output logic [C-1:0] head_final,
   output rrm_ctl_type  head_ctl
);

   logic [C-1:0]      row_ff [QUEUE_DEPTH];
   logic [C-1:0]      first_ff [QUEUE_DEPTH];
   logic [C-1:0]      final_ff [QUEUE_DEPTH];
   rrm_ctl_type       ctl_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   logic              do_pop;
   rrm_ctl_type       ctl_new;

   assign req_tready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;

   assign ctl_new.ok   = req_tuser && (req_tdata[3*C-1:2*C] >= req_tdata[2*C-1:C]);
   assign ctl_new.last = req_tlast;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         row_ff[wr_ptr_ff]   <= req_tdata[C-1:0];
         first_ff[wr_ptr_ff] <= req_tdata[2*C-1:C];
         final_ff[wr_ptr_ff] <= req_tdata[3*C-1:2*C];
         ctl_ff[wr_ptr_ff]   <= ctl_new;
      end
   end

   assign head_row   = row_ff[rd_ptr_ff];
   assign head_first = first_ff[rd_ptr_ff];
   assign head_final = final_ff[rd_ptr_ff];
   assign head_ctl   = ctl_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/rrm_accum.sv =====
// Run pipeline: closed-form run terms and the raw sums of the region.
module rrm_accum
   import rrm_pkg::*;
#(
   parameter int C = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  logic [C-1:0]      head_row,
   input  logic [C-1:0]      head_first,
   input  logic [C-1:0]      head_final,
   input  rrm_ctl_type       head_ctl,
   output logic              pop,
   input  logic              fin_busy,
   output logic              fin_start,
   output logic [2*C:0]      area_nx,
   output logic [3*C:0]      rsum_nx,
   output logic [3*C:0]      csum_nx,
   output logic [4*C:0]      rsq_nx,
   output logic [4*C:0]      rcs_nx,
   output logic [4*C:0]      csq_nx
);

   localparam int K  = C + 2;
   localparam int AW = 2*C + 1;
   localparam int SW = 3*C + 1;
   localparam int QW = 4*C + 1;
   localparam logic [K-1:0] INV3 = K'(((K % 2) == 0) ? (((64'd1 << (K+1)) + 64'd1) / 3)
                                                     : (((64'd1 << K) + 64'd1) / 3));
   localparam logic [K-1:0] MAXQ = K'(((64'd1 << K) - 64'd1) / 3);

   // Factors of n(n+1)(2n+1)/6 with the divisions by two and three done on single factors.
   function automatic logic [3*K-1:0] split_prefix(input logic [C-1:0] n);
      logic [K-1:0] fa, fb, fc, ta, tb, tc;
      fa = K'(n);
      fb = K'(n) + K'(1);
      fc = (K'(n) << 1) + K'(1);
      if (n[0]) begin
         fb = fb >> 1;
      end else begin
         fa = fa >> 1;
      end
      ta = fa * INV3;
      tb = fb * INV3;
      tc = fc * INV3;
      priority if (ta <= MAXQ) begin
         fa = ta;
      end else if (tb <= MAXQ) begin
         fb = tb;
      end else begin
         fc = tc;
      end
      return {fa, fb, fc};
   endfunction

   logic              adv;
   logic [C:0]        len0, sumc0;
   logic [C-1:0]      nb0;
   logic [3*K-1:0]    fe0, fb0;

   logic              s1_valid_ff;
   rrm_ctl_type       s1_ctl_ff;
   logic [C-1:0]      s1_row_ff;
   logic [C:0]        s1_len_ff, s1_sumc_ff;
   logic [3*K-1:0]    s1_fe_ff, s1_fb_ff;
   logic              s1_bz_ff;

   logic              s2_valid_ff;
   rrm_ctl_type       s2_ctl_ff;
   logic [C-1:0]      s2_row_ff;
   logic [C:0]        s2_len_ff;
   logic [2*C:0]      s2_rl_ff, s2_rl_in;
   logic [2*C+1:0]    s2_sl_ff, s2_sl_in;
   logic [2*C-1:0]    s2_rr_ff, s2_rr_in;
   logic [2*K-1:0]    s2_eab_ff, s2_eab_in, s2_bab_ff, s2_bab_in;
   logic [K-1:0]      s2_ec_ff, s2_bc_ff;
   logic              s2_bz_ff;

   logic              s3_valid_ff;
   rrm_ctl_type       s3_ctl_ff;
   logic [C:0]        s3_len_ff;
   logic [2*C:0]      s3_rl_ff, s3_sc_ff, sc2;
   logic [3*C:0]      s3_rrl_ff, s3_rrl_in, s3_rsc_ff, s3_rsc_in;
   logic [QW-1:0]     s3_pe_ff, s3_pe_in, s3_pb_ff, s3_pb_in;

   logic [AW-1:0]     area_ff;
   logic [SW-1:0]     rsum_ff, csum_ff;
   logic [QW-1:0]     rsq_ff, rcs_ff, csq_ff;
   logic              take;

   assign adv       = !(s3_valid_ff && s3_ctl_ff.last && fin_busy);
   assign pop       = adv && head_valid;
   assign take      = adv && s3_valid_ff;
   assign fin_start = take && s3_ctl_ff.last;

   assign len0  = {1'b0, head_final} - {1'b0, head_first} + (C+1)'(1);
   assign sumc0 = {1'b0, head_final} + {1'b0, head_first};
   assign nb0   = head_first - C'(1);
   assign fe0   = split_prefix(head_final);
   assign fb0   = split_prefix(nb0);

   assign s2_rl_in  = (2*C+1)'(s1_row_ff) * (2*C+1)'(s1_len_ff);
   assign s2_sl_in  = (2*C+2)'(s1_sumc_ff) * (2*C+2)'(s1_len_ff);
   assign s2_rr_in  = (2*C)'(s1_row_ff) * (2*C)'(s1_row_ff);
   assign s2_eab_in = (2*K)'(s1_fe_ff[3*K-1:2*K]) * (2*K)'(s1_fe_ff[2*K-1:K]);
   assign s2_bab_in = (2*K)'(s1_fb_ff[3*K-1:2*K]) * (2*K)'(s1_fb_ff[2*K-1:K]);

   assign sc2       = s2_sl_ff[2*C+1:1];
   assign s3_rrl_in = (3*C+1)'(s2_rr_ff) * (3*C+1)'(s2_len_ff);
   assign s3_rsc_in = (3*C+1)'(s2_row_ff) * (3*C+1)'(sc2);
   assign s3_pe_in  = QW'((3*K)'(s2_eab_ff) * (3*K)'(s2_ec_ff));
   assign s3_pb_in  = s2_bz_ff ? '0 : QW'((3*K)'(s2_bab_ff) * (3*K)'(s2_bc_ff));

   always_comb begin
      area_nx = area_ff;
      rsum_nx = rsum_ff;
      csum_nx = csum_ff;
      rsq_nx  = rsq_ff;
      rcs_nx  = rcs_ff;
      csq_nx  = csq_ff;
      if (s3_ctl_ff.ok) begin
         area_nx = area_ff + AW'(s3_len_ff);
         rsum_nx = rsum_ff + SW'(s3_rl_ff);
         csum_nx = csum_ff + SW'(s3_sc_ff);
         rsq_nx  = rsq_ff + QW'(s3_rrl_ff);
         rcs_nx  = rcs_ff + QW'(s3_rsc_ff);
         csq_nx  = csq_ff + s3_pe_ff - s3_pb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         area_ff     <= '0;
         rsum_ff     <= '0;
         csum_ff     <= '0;
         rsq_ff      <= '0;
         rcs_ff      <= '0;
         csq_ff      <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= head_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         if (take) begin
            if (s3_ctl_ff.last) begin
               area_ff <= '0;
               rsum_ff <= '0;
               csum_ff <= '0;
               rsq_ff  <= '0;
               rcs_ff  <= '0;
               csq_ff  <= '0;
            end else begin
               area_ff <= area_nx;
               rsum_ff <= rsum_nx;
               csum_ff <= csum_nx;
               rsq_ff  <= rsq_nx;
               rcs_ff  <= rcs_nx;
               csq_ff  <= csq_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff  <= head_ctl;
         s1_row_ff  <= head_row;
         s1_len_ff  <= len0;
         s1_sumc_ff <= sumc0;
         s1_fe_ff   <= fe0;
         s1_fb_ff   <= fb0;
         s1_bz_ff   <= (head_first == '0);

         s2_ctl_ff <= s1_ctl_ff;
         s2_row_ff <= s1_row_ff;
         s2_len_ff <= s1_len_ff;
         s2_rl_ff  <= s2_rl_in;
         s2_sl_ff  <= s2_sl_in;
         s2_rr_ff  <= s2_rr_in;
         s2_eab_ff <= s2_eab_in;
         s2_bab_ff <= s2_bab_in;
         s2_ec_ff  <= s1_fe_ff[K-1:0];
         s2_bc_ff  <= s1_fb_ff[K-1:0];
         s2_bz_ff  <= s1_bz_ff;

         s3_ctl_ff <= s2_ctl_ff;
         s3_len_ff <= s2_len_ff;
         s3_rl_ff  <= s2_rl_ff;
         s3_sc_ff  <= sc2;
         s3_rrl_ff <= s3_rrl_in;
         s3_rsc_ff <= s3_rsc_in;
         s3_pe_ff  <= s3_pe_in;
         s3_pb_ff  <= s3_pb_in;
      end
   end

endmodule

// ===== hw/rtl/rrm_finish.sv =====
// Region result: serial products, serial rounded divisions and the result register.
module rrm_finish
   import rrm_pkg::*;
#(
   parameter int C = 12,
   parameter int F = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*C:0]          area,
   input  logic [3*C:0]          rsum,
   input  logic [3*C:0]          csum,
   input  logic [4*C:0]          rsq,
   input  logic [4*C:0]          rcs,
   input  logic [4*C:0]          csq,
   output logic                  busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  status,
   output logic [AREA_OUT_W-1:0] region_area,
   output logic [CENT_W-1:0]     centroid_row,
   output logic [CENT_W-1:0]     centroid_col,
   output logic [MOM_W-1:0]      mixed_moment,
   output logic [MOM_W-1:0]      col_moment,
   output logic [MOM_W-1:0]      row_moment
);

   localparam int AW    = 2*C + 1;
   localparam int SW    = 3*C + 1;
   localparam int QW    = 4*C + 1;
   localparam int PW    = 6*C + 2;
   localparam int NW    = PW + F + 1;
   localparam int CW    = (NW > MOM_W + 1) ? NW : MOM_W + 1;
   localparam int CNT_W = $clog2(NW + 1);
   localparam logic [CW-1:0] LIM_CENT = CW'((64'd1 << CENT_W) - 64'd1);
   localparam logic [CW-1:0] LIM_MPOS = CW'((64'd1 << (MOM_W-1)) - 64'd1);
   localparam logic [CW-1:0] LIM_MNEG = CW'(64'd1 << (MOM_W-1));
   localparam logic [CW-1:0] LIM_MOM  = CW'((64'd1 << MOM_W) - 64'd1);

   fin_state_type state_ff, state_in;

   logic [AW-1:0]    a_ff;
   logic [SW-1:0]    rs_ff, cs_ff;
   logic [QW-1:0]    rss_ff, rcs_ff, css_ff;
   logic [PW-1:0]    p_ff [3];
   logic [PW-1:0]    q_ff [3];
   logic [2:0]       job_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PW-1:0]    acc_ff, acc_in, xs_ff;
   logic [SW-1:0]    y_ff;
   logic [PW-1:0]    mag_ff;
   logic             neg_ff;
   logic [NW-1:0]    num_ff, quo_ff;
   logic [AW-1:0]    rem_ff;
   logic [AW:0]      rem_sh;
   logic             ge;
   logic [CW-1:0]    quo_ext, lim, sat;

   logic                  status_ff;
   logic [AREA_OUT_W-1:0] area_out_ff;
   logic [CENT_W-1:0]     crow_ff, ccol_ff;
   logic [MOM_W-1:0]      mix_ff, cmom_ff, rmom_ff;

   assign acc_in  = y_ff[0] ? acc_ff + xs_ff : acc_ff;
   assign rem_sh  = {rem_ff, num_ff[NW-1]};
   assign ge      = (rem_sh >= {1'b0, a_ff});
   assign quo_ext = CW'(quo_ff);

   always_comb begin
      unique case (job_ff)
         DJ_CROW, DJ_CCOL: lim = LIM_CENT;
         DJ_MIX:           lim = neg_ff ? LIM_MNEG : LIM_MPOS;
         default:          lim = LIM_MOM;
      endcase
      sat = (quo_ext > lim) ? lim : quo_ext;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FIN_IDLE: if (start) state_in = (area == '0) ? FIN_OUT : FIN_MSET;
         FIN_MSET: state_in = FIN_MUL;
         FIN_MUL:  if (cnt_ff == '0) state_in = (job_ff == MJ_RR) ? FIN_PREP : FIN_MSET;
         FIN_PREP: state_in = FIN_LOAD;
         FIN_LOAD: state_in = FIN_DIV;
         FIN_DIV:  if (cnt_ff == '0) state_in = FIN_SAVE;
         FIN_SAVE: state_in = (job_ff == DJ_RMOM) ? FIN_OUT : FIN_PREP;
         FIN_OUT:  if (rsp_tready) state_in = FIN_IDLE;
         default:  state_in = FIN_IDLE;
      endcase
   end

   always_comb begin
      busy       = (state_ff != FIN_IDLE);
      rsp_tvalid = (state_ff == FIN_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         FIN_IDLE: begin
            a_ff        <= area;
            rs_ff       <= rsum;
            cs_ff       <= csum;
            rss_ff      <= rsq;
            rcs_ff      <= rcs;
            css_ff      <= csq;
            job_ff      <= MJ_RCA;
            status_ff   <= (area == '0);
            area_out_ff <= AREA_OUT_W'(area);
            crow_ff     <= '0;
            ccol_ff     <= '0;
            mix_ff      <= '0;
            cmom_ff     <= '0;
            rmom_ff     <= '0;
         end
         FIN_MSET: begin
            acc_ff <= '0;
            cnt_ff <= CNT_W'(SW - 1);
            unique case (job_ff)
               MJ_RCA: begin
                  xs_ff <= PW'(rcs_ff);
                  y_ff  <= SW'(a_ff);
               end
               MJ_RC: begin
                  xs_ff <= PW'(rs_ff);
                  y_ff  <= cs_ff;
               end
               MJ_CSA: begin
                  xs_ff <= PW'(css_ff);
                  y_ff  <= SW'(a_ff);
               end
               MJ_CC: begin
                  xs_ff <= PW'(cs_ff);
                  y_ff  <= cs_ff;
               end
               MJ_RSA: begin
                  xs_ff <= PW'(rss_ff);
                  y_ff  <= SW'(a_ff);
               end
               default: begin
                  xs_ff <= PW'(rs_ff);
                  y_ff  <= rs_ff;
               end
            endcase
         end
         FIN_MUL: begin
            acc_ff <= acc_in;
            xs_ff  <= xs_ff << 1;
            y_ff   <= y_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               unique case (job_ff)
                  MJ_RCA:  p_ff[0] <= acc_in;
                  MJ_RC:   q_ff[0] <= acc_in;
                  MJ_CSA:  p_ff[1] <= acc_in;
                  MJ_CC:   q_ff[1] <= acc_in;
                  MJ_RSA:  p_ff[2] <= acc_in;
                  default: q_ff[2] <= acc_in;
               endcase
               job_ff <= (job_ff == MJ_RR) ? DJ_CROW : job_ff + 1'b1;
            end
         end
         FIN_PREP: begin
            neg_ff <= 1'b0;
            unique case (job_ff)
               DJ_CROW: mag_ff <= PW'(rs_ff);
               DJ_CCOL: mag_ff <= PW'(cs_ff);
               DJ_MIX: begin
                  if (p_ff[0] < q_ff[0]) begin
                     mag_ff <= q_ff[0] - p_ff[0];
                     neg_ff <= 1'b1;
                  end else begin
                     mag_ff <= p_ff[0] - q_ff[0];
                  end
               end
               DJ_CMOM: mag_ff <= (p_ff[1] < q_ff[1]) ? '0 : p_ff[1] - q_ff[1];
               default: mag_ff <= (p_ff[2] < q_ff[2]) ? '0 : p_ff[2] - q_ff[2];
            endcase
         end
         FIN_LOAD: begin
            num_ff <= (NW'(mag_ff) << F) + NW'(a_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CNT_W'(NW - 1);
         end
         FIN_DIV: begin
            rem_ff <= ge ? AW'(rem_sh - {1'b0, a_ff}) : AW'(rem_sh);
            quo_ff <= {quo_ff[NW-2:0], ge};
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         FIN_SAVE: begin
            unique case (job_ff)
               DJ_CROW: crow_ff <= sat[CENT_W-1:0];
               DJ_CCOL: ccol_ff <= sat[CENT_W-1:0];
               DJ_MIX:  mix_ff  <= neg_ff ? MOM_W'(0) - sat[MOM_W-1:0] : sat[MOM_W-1:0];
               DJ_CMOM: cmom_ff <= sat[MOM_W-1:0];
               default: rmom_ff <= sat[MOM_W-1:0];
            endcase
            job_ff <= job_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign status       = status_ff;
   assign region_area  = area_out_ff;
   assign centroid_row = crow_ff;
   assign centroid_col = ccol_ff;
   assign mixed_moment = mix_ff;
   assign col_moment   = cmom_ff;
   assign row_moment   = rmom_ff;

endmodule

// ===== hw/rtl/rrm_checker.sv =====
// Port-level assertions of the run region moments unit and their binding.
`include "run_region_moments_unit_macros.svh"

module rrm_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [239:0] rsp_tdata,
   input logic         rsp_tuser
);

   `RRM_CHECK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "Result dropped while stalled.")
   `RRM_CHECK(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "Result changed while stalled.")
   `RRM_CHECK(a_empty_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == 240'd0, "Empty region carries nonzero fields.")
   `RRM_CHECK_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_tvalid, "Result offered right after reset.")

endmodule

bind run_region_moments_unit rrm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/run_region_moments_unit_tb.sv =====
// Self-checking testbench for the run region moments unit, with a stream model and scoreboard.
module run_region_moments_unit_tb
   import rrm_pkg::*;
();

   localparam int CB = 12;
   localparam int FB = 8;
   localparam int REQ_W = ((3*CB + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 800;

   typedef struct packed {
      logic              status;
      logic [24:0]       area;
      logic [19:0]       cent_row;
      logic [19:0]       cent_col;
      logic [MOM_W-1:0]  mixed;
      logic [MOM_W-1:0]  col_mom;
      logic [MOM_W-1:0]  row_mom;
   } moments_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // run_row, first_col, final_col, zero fill
   logic              req_tuser;   // has_run
   logic              req_tlast;   // region_end
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;   // region_area, centroid_row, centroid_col,
                                   // mixed_moment, col_moment, row_moment, zero fill
   logic              rsp_tuser;   // status

   run_region_moments_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

   logic [24:0] area_acc;
   logic [36:0] row_acc, col_acc;
   logic [48:0] row_sq_acc, row_col_acc, col_sq_acc;
   moments_type pending_regions[$];
   int          error_count = 0;
   int          items_sent = 0;
   int          regions_seen = 0;
   int          cycle_count = 0;
   bit          idle_enable = 1;
   int          hold_off = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] scaled_quotient(logic [127:0] num, logic [63:0] den,
                                                   logic [63:0] limit);
      logic [143:0] wide;
      logic [143:0] quot;
      wide = {16'b0, num} << FB;
      if (wide[143:128] != 0) return limit;
      wide = wide + (den / 2);
      if (wide[143:128] != 0) return limit;
      quot = wide / den;
      if (quot > limit) return limit;
      return quot[63:0];
   endfunction

   function automatic logic [63:0] square_prefix(logic [63:0] n);
      return n * (n + 1) * (2 * n + 1) / 6;
   endfunction

   task automatic accumulate_run(logic [CB-1:0] r, logic [CB-1:0] c0, logic [CB-1:0] c1,
                                 bit has, bit last);
      logic [63:0]  len, sc, sc2, a;
      logic [127:0] p, q;
      logic [63:0]  lim55, lim56, mag;
      moments_type  res;
      lim55 = (64'd1 << 55) - 1;
      lim56 = (64'd1 << 56) - 1;
      if (has && c1 >= c0) begin
         len = c1 - c0 + 1;
         sc = ((64'(c0) + c1) * len) / 2;
         sc2 = square_prefix(c1) - ((c0 != 0) ? square_prefix(c0 - 1) : 64'd0);
         area_acc += len;
         row_acc += 64'(r) * len;
         col_acc += sc;
         row_sq_acc += 64'(r) * r * len;
         row_col_acc += 64'(r) * sc;
         col_sq_acc += sc2;
      end
      if (!last) return;
      res = '0;
      a = area_acc;
      if (a == 0) begin
         res.status = 1'b1;
      end else begin
         res.area = area_acc;
         res.cent_row = scaled_quotient(128'(row_acc), a, 64'hFFFFF);
         res.cent_col = scaled_quotient(128'(col_acc), a, 64'hFFFFF);
         p = 128'(row_col_acc) * a;
         q = 128'(row_acc) * col_acc;
         if (p < q) begin
            mag = scaled_quotient(q - p, a, lim55 + 1);
            res.mixed = (64'd0 - mag);
         end else begin
            res.mixed = scaled_quotient(p - q, a, lim55);
         end
         p = 128'(col_sq_acc) * a;
         q = 128'(col_acc) * col_acc;
         res.col_mom = (p < q) ? 64'd0 : scaled_quotient(p - q, a, lim56);
         p = 128'(row_sq_acc) * a;
         q = 128'(row_acc) * row_acc;
         res.row_mom = (p < q) ? 64'd0 : scaled_quotient(p - q, a, lim56);
      end
      pending_regions.insert(pending_regions.size(), res);
      area_acc = 0; row_acc = 0; col_acc = 0;
      row_sq_acc = 0; row_col_acc = 0; col_sq_acc = 0;
   endtask

   task automatic send_run(logic [CB-1:0] r, logic [CB-1:0] c0, logic [CB-1:0] c1,
                           bit has, bit last);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {{(REQ_W-3*CB){1'b0}}, c1, c0, r};
      req_tuser = has;
      req_tlast = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      accumulate_run(r, c0, c1, has, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH region %0d %s: got %h expected %h", regions_seen, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      moments_type got, want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.area = rsp_tdata[24:0];
         got.cent_row = rsp_tdata[44:25];
         got.cent_col = rsp_tdata[64:45];
         got.mixed = rsp_tdata[120:65];
         got.col_mom = rsp_tdata[176:121];
         got.row_mom = rsp_tdata[232:177];
         if (pending_regions.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_tuser), 64'd0);
         end else begin
            want = pending_regions.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.area != want.area) report_mismatch("area", got.area, want.area);
            if (got.cent_row != want.cent_row)
               report_mismatch("centroid_row", got.cent_row, want.cent_row);
            if (got.cent_col != want.cent_col)
               report_mismatch("centroid_col", got.cent_col, want.cent_col);
            if (got.mixed != want.mixed) report_mismatch("mixed_moment", got.mixed, want.mixed);
            if (got.col_mom != want.col_mom)
               report_mismatch("col_moment", got.col_mom, want.col_mom);
            if (got.row_mom != want.row_mom)
               report_mismatch("row_moment", got.row_mom, want.row_mom);
         end
         regions_seen++;
      end
   end

   initial begin
      int burst;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready = 1'b0;
            hold_off--;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_tready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic logic [CB-1:0] pick_coord();
      unique case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return CB'($urandom_range(0, (1 << CB) - 1));
      endcase
   endfunction

   task automatic send_random_region();
      int n;
      logic [CB-1:0] r, c0, c1, t;
      bit has;
      n = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 10);
      for (int i = 0; i <= n; i++) begin
         r = pick_coord();
         c0 = pick_coord();
         c1 = ($urandom_range(0, 1)) ? pick_coord() : c0 + $urandom_range(0, 40);
         if (c1 < c0 && $urandom_range(0, 7) != 0) begin
            t = c0; c0 = c1; c1 = t;
         end
         has = (i < n) ? ($urandom_range(0, 9) != 0) : $urandom_range(0, 1);
         send_run(r, c0, c1, has, i == n);
      end
   endtask

   task automatic test_directed();
      send_run(0, 0, 0, 0, 1);
      send_run(0, 0, 0, 1, 1);
      send_run('1, '1, '1, 1, 1);
      send_run(0, 0, '1, 1, 1);
      send_run('1, 0, '1, 1, 0);
      send_run(0, 0, '1, 1, 1);
      send_run(5, 10, 3, 1, 1);
      send_run(7, 100, 200, 1, 0);
      send_run(9, 0, 0, 0, 0);
      send_run(8, 50, 20, 1, 0);
      send_run(3, 4095, 4095, 1, 1);
      send_run(12'hAAA, 12'h555, 12'hAAA, 1, 0);
      send_run(12'h555, 12'h2AA, 12'h555, 1, 1);
      send_run(1, 2, 3, 0, 1);
   endtask

   task automatic test_random_regions(int item_goal);
      while (items_sent < item_goal) send_random_region();
   endtask

   task automatic test_backpressure();
      hold_off = 3000;
      for (int i = 0; i < 12; i++) send_random_region();
   endtask

   task automatic test_no_idle(int item_goal);
      idle_enable = 0;
      while (items_sent < item_goal) send_random_region();
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      area_acc = 0; row_acc = 0; col_acc = 0;
      row_sq_acc = 0; row_col_acc = 0; col_sq_acc = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_regions(400);
      test_backpressure();
      test_random_regions(600);
      test_no_idle(720);
      req_tvalid = 1'b0;
      while (pending_regions.size() != 0) @(posedge clock);
      waited = 0;
      while (waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      $display("Sent %0d run transactions and checked %0d region results,", items_sent,
               regions_seen);
      $display("including empty, reversed and marker runs and a long receiver stall.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
